@@ design/mrf_pkg.sv @@
// shared types, constants and crc table for the modbus rtu request framer
// no dependencies; used by mrf_crc_pipe, mrf_tx_shift and the top level

package mrf_pkg;

   // request payload layout on req_tdata, lowest bit first
   localparam int REQ_DATA_W  = 72;
   localparam int SLAVE_LSB   = 0;
   localparam int ADDR_LSB    = 8;
   localparam int VALUE_LSB   = 24;
   localparam int DIR_LSB     = 40;
   localparam int ACCEL_LSB   = 41;
   localparam int RPM_LSB     = 49;

   // frame geometry
   localparam int BODY_MAX        = 11;
   localparam int FRAME_MAX       = 13;
   localparam int SINGLE_BODY_LEN = 6;
   localparam int RUN_BODY_LEN    = 11;
   localparam int BYTES_PER_STAGE = 2;
   localparam int NUM_STAGES      = (BODY_MAX + BYTES_PER_STAGE - 1) / BYTES_PER_STAGE;
   localparam logic [3:0] SINGLE_FRAME_LEN = 4'd8;
   localparam logic [3:0] RUN_FRAME_LEN    = 4'd13;

   // command codes carried on tuser
   typedef enum logic {
      CMD_WRITE_SINGLE = 1'b0,
      CMD_SPEED_RUN    = 1'b1
   } cmd_type;

   // modbus frame constants
   localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;
   localparam logic [7:0] FUNC_WRITE_MULTI  = 8'h10;
   localparam logic [7:0] RUN_START_HI      = 8'h00;
   localparam logic [7:0] RUN_START_LO      = 8'hF6;
   localparam logic [7:0] RUN_QTY_HI        = 8'h00;
   localparam logic [7:0] RUN_QTY_LO        = 8'h02;
   localparam logic [7:0] RUN_BYTE_COUNT    = 8'h04;
   localparam logic [7:0] DIR_CW_BYTE       = 8'h01;
   localparam logic [7:0] DIR_CCW_BYTE      = 8'h00;
   localparam logic [15:0] CRC_INIT         = 16'hFFFF;
   localparam logic [15:0] CRC_POLY         = 16'hA001;

   // frame body with running crc, travels through the crc stages
   typedef struct packed {
      logic                     run;
      logic [BODY_MAX-1:0][7:0] body;
      logic [15:0]              crc;
   } frame_type;

   typedef logic [15:0] crc_table_type [256];

   // byte-wise crc table, built at elaboration
   function automatic crc_table_type gen_crc_table();
      crc_table_type t;
      logic [15:0]   c;
      for (int i = 0; i < 256; i++) begin
         c = 16'(i);
         for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
         t[i] = c;
      end
      return t;
   endfunction

   localparam crc_table_type CRC_TABLE = gen_crc_table();

   // absorb one byte into the crc
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0] idx;
      idx = crc[7:0] ^ b;
      return {8'h00, crc[15:8]} ^ CRC_TABLE[idx];
   endfunction

endpackage

@@ design/modbus_rtu_request_framer.sv @@
// modbus rtu request framer: request in, framed bytes with crc-16 out
// a request passes through the crc stages and the serializer register before its first
// byte is valid; output is one byte per cycle while rsp_tready is high, 8 bytes per
// write-single frame and 13 per speed-run frame; six crc stages buffer requests
// reset: synchronous active high, empties the crc stages and the serializer
// depends on mrf_pkg, mrf_crc_pipe, mrf_tx_shift

module modbus_rtu_request_framer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // slave[7:0], reg_addr[23:8], reg_value[39:24], dir_cw[40], accel[48:41],
   // rpm[64:49], zero fill [71:65]
   input  logic [mrf_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd[0]
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tx_byte[7:0]
   output logic [7:0]                     rsp_tdata,
   output logic                           rsp_tlast
);
   import mrf_pkg::*;

   logic      frame_valid;
   logic      frame_ready;
   frame_type frame;

   // frame assembly and crc stages
   mrf_crc_pipe u_crc_pipe (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (req_tuser),
      .req_data    (req_tdata),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .frame       (frame)
   );

   // byte serializer
   mrf_tx_shift u_tx_shift (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .frame       (frame),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_byte    (rsp_tdata),
      .out_last    (rsp_tlast)
   );

   // a frame does not end before its last byte
   a_frame_continues : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("frame ended without last byte");

   // a loaded frame shows up on the output
   a_load_visible : assert property (@(posedge clock) disable iff (reset)
      frame_valid && frame_ready |=> rsp_tvalid)
      else $error("loaded frame not presented");

   // an idle serializer always takes a frame
   a_idle_accepts : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> frame_ready)
      else $error("idle serializer refused a frame");

endmodule

@@ design/mrf_crc_pipe.sv @@
// frame assembly and pipelined crc-16 over the frame body, up to two bytes per stage
// depends on mrf_pkg

module mrf_crc_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [mrf_pkg::REQ_DATA_W-1:0] req_data,
   output logic                          frame_valid,
   input  logic                          frame_ready,
   output mrf_pkg::frame_type            frame
);
   import mrf_pkg::*;

   frame_type                 built;
   frame_type                 stage_ff [NUM_STAGES];
   frame_type                 stage_in [NUM_STAGES];
   logic [NUM_STAGES-1:0]     valid_ff;
   logic [NUM_STAGES:0]       ready;

   // assemble the frame body from the request
   always_comb begin
      built     = '0;
      built.crc = CRC_INIT;
      built.body[0] = req_data[SLAVE_LSB +: 8];
      if (cmd_type'(req_cmd) == CMD_SPEED_RUN) begin
         built.run      = 1'b1;
         built.body[1]  = FUNC_WRITE_MULTI;
         built.body[2]  = RUN_START_HI;
         built.body[3]  = RUN_START_LO;
         built.body[4]  = RUN_QTY_HI;
         built.body[5]  = RUN_QTY_LO;
         built.body[6]  = RUN_BYTE_COUNT;
         built.body[7]  = req_data[DIR_LSB] ? DIR_CW_BYTE : DIR_CCW_BYTE;
         built.body[8]  = req_data[ACCEL_LSB +: 8];
         built.body[9]  = req_data[RPM_LSB + 8 +: 8];
         built.body[10] = req_data[RPM_LSB +: 8];
      end else begin
         built.run     = 1'b0;
         built.body[1] = FUNC_WRITE_SINGLE;
         built.body[2] = req_data[ADDR_LSB + 8 +: 8];
         built.body[3] = req_data[ADDR_LSB +: 8];
         built.body[4] = req_data[VALUE_LSB + 8 +: 8];
         built.body[5] = req_data[VALUE_LSB +: 8];
      end
   end

   // stall chain: a stage loads when empty or when its successor loads
   assign ready[NUM_STAGES] = frame_ready;
   assign req_ready         = ready[0];

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      frame_type src;
      logic      src_valid;

      if (s == 0) begin : g_first
         assign src       = built;
         assign src_valid = req_valid;
      end else begin : g_next
         assign src       = stage_ff[s-1];
         assign src_valid = valid_ff[s-1];
      end

      assign ready[s] = !valid_ff[s] || ready[s+1];

      // absorb this stage's body bytes that lie inside the frame
      always_comb begin
         stage_in[s] = src;
         for (int j = 0; j < BYTES_PER_STAGE; j++) begin
            if (s * BYTES_PER_STAGE + j < SINGLE_BODY_LEN) begin
               stage_in[s].crc = crc_byte(stage_in[s].crc,
                                          src.body[s * BYTES_PER_STAGE + j]);
            end else if (s * BYTES_PER_STAGE + j < RUN_BODY_LEN) begin
               if (src.run) begin
                  stage_in[s].crc = crc_byte(stage_in[s].crc,
                                             src.body[s * BYTES_PER_STAGE + j]);
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (ready[s]) begin
            valid_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[s] && src_valid) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign frame_valid = valid_ff[NUM_STAGES-1];
   assign frame       = stage_ff[NUM_STAGES-1];

endmodule

@@ design/mrf_tx_shift.sv @@
// byte serializer: loads a finished frame and shifts it out one byte per cycle while out_ready is high
// depends on mrf_pkg

module mrf_tx_shift (
   input  logic               clock,
   input  logic               reset,
   input  logic               frame_valid,
   output logic               frame_ready,
   input  mrf_pkg::frame_type frame,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         out_byte,
   output logic               out_last
);
   import mrf_pkg::*;

   logic [FRAME_MAX-1:0][7:0] shift_ff;
   logic [FRAME_MAX-1:0][7:0] shift_in;
   logic [3:0]                count_ff;
   logic [3:0]                count_in;
   logic [FRAME_MAX-1:0][7:0] load_bytes;
   logic                      take;
   logic                      load;

   assign out_valid = count_ff != 4'd0;
   assign out_last  = count_ff == 4'd1;
   assign out_byte  = shift_ff[0];
   assign take      = out_valid && out_ready;

   // the next frame enters as the last byte of the current one leaves
   assign frame_ready = !out_valid || (out_last && take);
   assign load        = frame_ready && frame_valid;

   // body followed by crc, low byte first
   always_comb begin
      load_bytes = '0;
      if (frame.run) begin
         for (int i = 0; i < RUN_BODY_LEN; i++) begin
            load_bytes[i] = frame.body[i];
         end
         load_bytes[RUN_BODY_LEN]     = frame.crc[7:0];
         load_bytes[RUN_BODY_LEN + 1] = frame.crc[15:8];
      end else begin
         for (int i = 0; i < SINGLE_BODY_LEN; i++) begin
            load_bytes[i] = frame.body[i];
         end
         load_bytes[SINGLE_BODY_LEN]     = frame.crc[7:0];
         load_bytes[SINGLE_BODY_LEN + 1] = frame.crc[15:8];
      end
   end

   // next shift contents and byte count
   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      if (load) begin
         shift_in = load_bytes;
         count_in = frame.run ? RUN_FRAME_LEN : SINGLE_FRAME_LEN;
      end else if (take) begin
         shift_in = {8'h00, shift_ff[FRAME_MAX-1:1]};
         count_in = count_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

endmodule

@@ tb/tb_modbus_rtu_request_framer.sv @@
// testbench for modbus_rtu_request_framer: random and directed requests, a local
// frame and crc-16 predictor, byte-by-byte checking of the response stream
// depends on mrf_pkg and modbus_rtu_request_framer

module tb_modbus_rtu_request_framer;
   timeunit 1ns;
   timeprecision 1ps;

   import mrf_pkg::*;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
   } frame_byte_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // slave[7:0], reg_addr[23:8], reg_value[39:24], dir_cw[40], accel[48:41],
   // rpm[64:49], zero fill [71:65]
   logic [REQ_DATA_W-1:0] req_tdata;
   // cmd[0]
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // tx_byte[7:0]
   logic [7:0]            rsp_tdata;
   logic                  rsp_tlast;

   // frame bytes still to come out, oldest first
   frame_byte_type frame_bytes_due[$];
   int             mismatch_count;
   int             send_idle_pct;
   int             recv_idle_pct;
   int             rsp_hold_cycles;

   modbus_rtu_request_framer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock, 12 ns period
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog
   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end

   // crc-16 over the first count bytes, bit-serial
   function automatic logic [15:0] crc16_over_bytes(input logic [7:0] octets [FRAME_MAX],
                                                    input int count);
      logic [15:0] acc;
      acc = CRC_INIT;
      for (int i = 0; i < count; i++) begin
         acc = acc ^ {8'h00, octets[i]};
         for (int b = 0; b < 8; b++) begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
         end
      end
      return acc;
   endfunction

   // build the expected frame for one request and queue its bytes
   function automatic void predict_frame(input cmd_type cmd, input logic [7:0] slave,
                                         input logic [15:0] reg_addr,
                                         input logic [15:0] reg_value,
                                         input logic dir_cw, input logic [7:0] accel,
                                         input logic [15:0] rpm);
      logic [7:0]     octets [FRAME_MAX];
      int             total;
      logic [15:0]    crc;
      frame_byte_type fb;
      foreach (octets[i]) octets[i] = 8'h00;
      octets[0] = slave;
      if (cmd == CMD_WRITE_SINGLE) begin
         octets[1] = FUNC_WRITE_SINGLE;
         octets[2] = reg_addr[15:8];
         octets[3] = reg_addr[7:0];
         octets[4] = reg_value[15:8];
         octets[5] = reg_value[7:0];
         total = 8;
      end else begin
         octets[1]  = FUNC_WRITE_MULTI;
         octets[2]  = RUN_START_HI;
         octets[3]  = RUN_START_LO;
         octets[4]  = RUN_QTY_HI;
         octets[5]  = RUN_QTY_LO;
         octets[6]  = RUN_BYTE_COUNT;
         octets[7]  = dir_cw ? DIR_CW_BYTE : DIR_CCW_BYTE;
         octets[8]  = accel;
         octets[9]  = rpm[15:8];
         octets[10] = rpm[7:0];
         total = 13;
      end
      crc = crc16_over_bytes(octets, total - 2);
      // crc goes out low byte first
      octets[total-2] = crc[7:0];
      octets[total-1] = crc[15:8];
      for (int k = 0; k < total; k++) begin
         fb.tx_byte   = octets[k];
         fb.last_byte = (k == total - 1);
         frame_bytes_due.push_back(fb);
      end
   endfunction

   // one line per mismatch
   task automatic report_mismatch(input string what, input logic [7:0] expected,
                                  input logic [7:0] actual);
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %02h, got %02h", $realtime, what,
               expected, actual);
   endtask

   // response checker, sampled at the rising edge
   always @(posedge clock) begin
      frame_byte_type fb;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (frame_bytes_due.size() == 0) begin
            report_mismatch("unexpected byte", 8'h00, rsp_tdata);
         end else begin
            fb = frame_bytes_due.pop_front();
            if (rsp_tdata !== fb.tx_byte) begin
               report_mismatch("tx_byte", fb.tx_byte, rsp_tdata);
            end
            if (rsp_tlast !== fb.last_byte) begin
               report_mismatch("last_byte", {7'h00, fb.last_byte}, {7'h00, rsp_tlast});
            end
         end
      end
   end

   // response ready: random idling, plus long hold-offs counted here
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // offer one request from the falling edge on, return once it is taken
   task automatic send_request(input cmd_type cmd, input logic [7:0] slave,
                               input logic [15:0] reg_addr, input logic [15:0] reg_value,
                               input logic dir_cw, input logic [7:0] accel,
                               input logic [15:0] rpm);
      logic [REQ_DATA_W-1:0] word;
      word = '0;
      word[SLAVE_LSB +: 8]  = slave;
      word[ADDR_LSB  +: 16] = reg_addr;
      word[VALUE_LSB +: 16] = reg_value;
      word[DIR_LSB]         = dir_cw;
      word[ACCEL_LSB +: 8]  = accel;
      word[RPM_LSB   +: 16] = rpm;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      predict_frame(cmd, slave, reg_addr, reg_value, dir_cw, accel, rpm);
   endtask

   // stop offering requests
   task automatic release_request;
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // wait until every queued frame byte has come out
   task automatic wait_frames_drained;
      while (frame_bytes_due.size() != 0) @(posedge clock);
   endtask

   // random fields, now and then at their extremes
   function automatic logic [15:0] pick16;
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick8;
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_random_request;
      cmd_type cmd;
      cmd = $urandom_range(1) ? CMD_SPEED_RUN : CMD_WRITE_SINGLE;
      send_request(cmd, pick8(), pick16(), pick16(), 1'($urandom), pick8(), pick16());
   endtask

   // write-single frames at field extremes, unused fields given mixed patterns
   task automatic test_write_single_extremes;
      send_request(CMD_WRITE_SINGLE, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'hFF, 16'hFFFF);
      send_request(CMD_WRITE_SINGLE, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 16'hFFFF);
      send_request(CMD_WRITE_SINGLE, 8'h01, 16'h5555, 16'hAAAA, 1'b0, 8'h00, 16'h0000);
      send_request(CMD_WRITE_SINGLE, 8'hAA, 16'hAAAA, 16'h5555, 1'b1, 8'h55, 16'hAAAA);
      send_request(CMD_WRITE_SINGLE, 8'h55, 16'h00F6, 16'h8001, 1'b0, 8'hAA, 16'h5555);
      send_request(CMD_WRITE_SINGLE, 8'h80, 16'h8000, 16'h0001, 1'b1, 8'h80, 16'h8000);
   endtask

   // speed-run frames at field extremes, ignored address and value given mixed patterns
   task automatic test_speed_run_extremes;
      send_request(CMD_SPEED_RUN, 8'h00, 16'hFFFF, 16'hFFFF, 1'b0, 8'h00, 16'h0000);
      send_request(CMD_SPEED_RUN, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 16'hFFFF);
      send_request(CMD_SPEED_RUN, 8'h01, 16'h0000, 16'h0000, 1'b1, 8'h00, 16'h0BB8);
      send_request(CMD_SPEED_RUN, 8'hAA, 16'h5555, 16'hAAAA, 1'b0, 8'h55, 16'hAAAA);
      send_request(CMD_SPEED_RUN, 8'h55, 16'hAAAA, 16'h5555, 1'b1, 8'hAA, 16'h5555);
      send_request(CMD_SPEED_RUN, 8'h7F, 16'h1234, 16'h5678, 1'b0, 8'h01, 16'h8000);
   endtask

   // alternating commands, with the sender pausing once until all bytes are out
   task automatic test_mixed_with_drain;
      send_request(CMD_WRITE_SINGLE, 8'h11, 16'h0100, 16'h00FF, 1'b0, 8'h00, 16'h0000);
      send_request(CMD_SPEED_RUN, 8'h11, 16'h0000, 16'h0000, 1'b1, 8'h0A, 16'h01F4);
      send_request(CMD_WRITE_SINGLE, 8'h22, 16'hFF00, 16'hFF00, 1'b1, 8'hFF, 16'hFFFF);
      release_request();
      wait_frames_drained();
      send_request(CMD_SPEED_RUN, 8'h22, 16'hFFFF, 16'h0000, 1'b0, 8'hFF, 16'h00FF);
      send_request(CMD_WRITE_SINGLE, 8'h33, 16'h0006, 16'h0010, 1'b0, 8'h00, 16'h0000);
      send_request(CMD_SPEED_RUN, 8'h33, 16'h0000, 16'hFFFF, 1'b1, 8'h80, 16'hFF00);
   endtask

   // long receiver hold-off while requests keep coming, so the input stalls
   task automatic test_output_backpressure;
      rsp_hold_cycles = 400;
      repeat (24) send_random_request();
      release_request();
      wait_frames_drained();
   endtask

   // random requests under one idling mix
   task automatic test_random_traffic(input int count, input int send_pct,
                                      input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) send_random_request();
   endtask

   // stimulus sequence
   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = 1'b0;
      mismatch_count  = 0;
      send_idle_pct   = 36;
      recv_idle_pct   = 53;
      rsp_hold_cycles = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_write_single_extremes();
      test_speed_run_extremes();
      test_mixed_with_drain();
      test_output_backpressure();
      test_random_traffic(128, 36, 53);
      test_random_traffic(128, 53, 36);
      test_random_traffic(128, 0, 0);
      release_request();

      // let any stray bytes show up before the verdict
      wait_frames_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
